// ===== rtl/spsg_pkg.sv =====
// Shared types, codes and constant wheel helpers for the segmented prime sieve generator.
`default_nettype none
package spsg_pkg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_BB_FILL,
        ST_BB_RD,
        ST_BB_CHK,
        ST_BB_CLR,
        ST_IO_RD,
        ST_IO_CHK,
        ST_IO_DIV,
        ST_IO_FIN,
        ST_WH_SETUP,
        ST_WH_INIT,
        ST_WH_CONV,
        ST_WH_FILL,
        ST_CX_RD,
        ST_CX_CHK,
        ST_CX_TEST,
        ST_CX_WR,
        ST_SC_WORD,
        ST_SC_BIT,
        ST_RESP
    } state_t;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_NEXT  = 1'b1;

    localparam logic [1:0] STAT_PRIME   = 2'd0;
    localparam logic [1:0] STAT_DONE    = 2'd1;
    localparam logic [1:0] STAT_REJECT  = 2'd2;
    localparam logic [1:0] STAT_STARTED = 2'd3;

    localparam logic [1:0] ADDR_LIMIT = 2'd0;

    localparam int unsigned NUM_SMALL = 10;
    localparam int unsigned SMALL_PRIME [NUM_SMALL] = '{3, 5, 7, 11, 13, 17, 19, 23, 29, 31};

    localparam int unsigned FIRST_SIEVE_SLOT = 18;

    localparam logic [31:0] WORD0_MASK = 32'h76d3_2d26;
    localparam logic [31:0] TOP_BIT    = 32'h8000_0000;

    function automatic logic [31:0] wheel_pattern(input int unsigned p);
        logic [31:0] pat;
        int unsigned c;
        pat = '0;
        c = 0;
        for (int j = 0; j < 32; j++) begin
            if (c == 0) pat[31-j] = 1'b1;
            c = (c == p - 1) ? 0 : c + 1;
        end
        return pat;
    endfunction

    function automatic int unsigned mod32(input int unsigned p);
        int unsigned r;
        r = 32;
        for (int j = 0; j < 32; j++) begin
            if (r >= p) r = r - p;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/segmented_prime_sieve_generator.sv =====
// Top level of the segmented odd-prime generator: sequencer, sieve stores and APB limit register.
`default_nettype none
// Odd primes in ascending order below the limit register. A start item (command 0) places the
// search at the smallest odd number not below start_value and answers status 3, or status 2
// when start_value exceeds the limit. Each next item (command 1) answers one prime with status
// 0, or status 1 once the limit is reached. The block takes one item at a time. A start builds
// the base-prime table, finds the first multiple of each base prime (by a serial remainder where
// its square lies below the segment start), then runs a segment sieve. A segment sieve sets up
// the wheel, fills the segment words from the wheel and crosses the multiples of each base prime
// in the segment memory. A next item scans odd candidates word by word and runs a segment sieve
// when the scan leaves the current segment.
module segmented_prime_sieve_generator #(
    parameter int SEG_WORDS  = 1024,
    parameter int BASE_SLOTS = 2048,
    parameter int LIMIT_BITS = 24
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire                   s_command,
    input  wire  [LIMIT_BITS-1:0] s_start_value,
    output logic                  m_valid,
    input  wire                   m_ready,
    output logic [LIMIT_BITS-1:0] m_prime,
    output logic [1:0]            m_status,
    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire  [1:0]            paddr,
    input  wire  [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int SEGB  = $clog2(SEG_WORDS);
    localparam int WPW   = $clog2(SEG_WORDS + 1);
    localparam int SPAN  = SEG_WORDS * 32;
    localparam int SPANW = $clog2(SPAN + 1);
    localparam int BSB   = $clog2(BASE_SLOTS);
    localparam int IW    = $clog2(BASE_SLOTS + 1);
    localparam int PW    = BSB + 1;
    localparam int SQW   = 2 * PW;
    localparam int WBW   = ((LIMIT_BITS - 6 > SEGB) ? LIMIT_BITS - 6 : SEGB) + 1;
    localparam int NW    = WBW + 6;
    localparam int CW    = ((SQW > NW) ? SQW : NW) + 1;
    localparam int OW    = ((SQW > SPANW) ? SQW : SPANW) + 1;
    localparam int CNTW  = $clog2(NW + 1);
    localparam int NS    = spsg_pkg::NUM_SMALL;

    spsg_pkg::state_t state_reg, state_next;

    logic [LIMIT_BITS-1:0] limit_reg, limit_next;
    logic [WBW-1:0]        base_reg, base_next;
    logic [WPW-1:0]        wp_reg, wp_next;
    logic [4:0]            bp_reg, bp_next;
    logic                  done_reg, done_next;
    logic                  resume_reg, resume_next;
    logic [IW-1:0]         i_reg, i_next;
    logic [SQW-1:0]        sq_reg, sq_next;
    logic [SQW-1:0]        mult_reg, mult_next;
    logic [OW-1:0]         o_reg, o_next;
    logic [PW-1:0]         rem_reg, rem_next;
    logic [CNTW-1:0]       cnt_reg, cnt_next;
    logic [NW-1:0]         sh_reg, sh_next;
    logic [WPW-1:0]        fw_reg, fw_next;
    logic [4:0]            lane_reg [NS];
    logic [4:0]            lane_next [NS];
    logic [LIMIT_BITS-1:0] res_prime_reg, res_prime_next;
    logic [1:0]            res_status_reg, res_status_next;
    logic                  m_valid_reg, m_valid_next;
    logic [LIMIT_BITS-1:0] m_prime_reg, m_prime_next;
    logic [1:0]            m_status_reg, m_status_next;

    logic [31:0] seg_mem [SEG_WORDS];
    logic [31:0] seg_rdata_reg;
    logic        seg_we, seg_re;
    logic [SEGB-1:0] seg_waddr, seg_raddr;
    logic [31:0] seg_wdata;

    logic        base_mem [BASE_SLOTS];
    logic        base_rbit_reg;
    logic        base_we, base_wbit;
    logic [BSB-1:0] base_waddr;

    logic [OW-1:0] off_mem [BASE_SLOTS];
    logic [OW-1:0] off_rdata_reg;
    logic          off_we;
    logic [OW-1:0] off_wdata;

    logic [PW-1:0]  p_w;
    logic [NW-1:0]  seg_start_w;
    logic [CW-1:0]  sq_ext, seg_ext;
    logic [PW:0]    rem_trial;
    logic [PW:0]    d_odd;
    logic [PW-1:0]  d_raw;
    logic [WBW-1:0] abs_word;
    logic [NW-1:0]  n_w;
    logic [31:0]    shifted_word;
    logic [31:0]    wheel_and;
    logic [4:0]     init_val [NS];
    logic [4:0]     conv_val [NS];
    logic [4:0]     step_val [NS];
    logic [31:0]    clr_mask [NS];

    assign p_w         = {i_reg[BSB-1:0], 1'b1};
    assign seg_start_w = {base_reg, 6'b0};
    assign sq_ext      = CW'(sq_reg);
    assign seg_ext     = CW'(seg_start_w);
    assign rem_trial   = {rem_reg, sh_reg[NW-1]};
    assign d_raw       = (rem_reg == '0) ? '0 : p_w - rem_reg;
    assign d_odd       = d_raw[0] ? {1'b0, d_raw} : {1'b0, d_raw} + {1'b0, p_w};
    assign abs_word    = base_reg + WBW'(wp_reg);
    assign n_w         = {abs_word, bp_reg, 1'b1};
    assign shifted_word = seg_rdata_reg << bp_reg;

    for (genvar k = 0; k < NS; k++) begin : g_lane
        localparam logic [6:0] P7  = 7'(spsg_pkg::SMALL_PRIME[k]);
        localparam logic [4:0] P   = 5'(spsg_pkg::SMALL_PRIME[k]);
        localparam logic [6:0] H7  = 7'((spsg_pkg::SMALL_PRIME[k] + 1) / 2);
        localparam logic [4:0] D   = 5'(spsg_pkg::mod32(spsg_pkg::SMALL_PRIME[k]));
        localparam logic [31:0] PAT = spsg_pkg::wheel_pattern(spsg_pkg::SMALL_PRIME[k]);
        logic [6:0] dbl, sub1;
        assign dbl  = {1'b0, lane_reg[k], 1'b0} + (sh_reg[NW-1] ? H7 : 7'd0);
        assign sub1 = (dbl >= P7) ? dbl - P7 : dbl;
        assign init_val[k] = (sub1 >= P7) ? 5'(sub1 - P7) : 5'(sub1);
        assign conv_val[k] = (lane_reg[k] == 5'd0) ? 5'd0 : P - lane_reg[k];
        assign step_val[k] = (lane_reg[k] >= D) ? lane_reg[k] - D : lane_reg[k] + (P - D);
        assign clr_mask[k] = ~(PAT >> lane_reg[k]);
    end

    always_comb begin
        wheel_and = '1;
        for (int k = 0; k < NS; k++) begin
            wheel_and = wheel_and & clr_mask[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (seg_we) seg_mem[seg_waddr] <= seg_wdata;
        if (seg_re) seg_rdata_reg <= seg_mem[seg_raddr];
    end

    always_ff @(posedge aclk) begin
        if (base_we) base_mem[base_waddr] <= base_wbit;
        base_rbit_reg <= base_mem[i_reg[BSB-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (off_we) off_mem[i_reg[BSB-1:0]] <= off_wdata;
        off_rdata_reg <= off_mem[i_reg[BSB-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= spsg_pkg::ST_IDLE;
            limit_reg   <= '1;
            base_reg    <= '0;
            wp_reg      <= '0;
            bp_reg      <= '0;
            done_reg    <= 1'b1;
            resume_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            limit_reg   <= limit_next;
            base_reg    <= base_next;
            wp_reg      <= wp_next;
            bp_reg      <= bp_next;
            done_reg    <= done_next;
            resume_reg  <= resume_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg          <= i_next;
        sq_reg         <= sq_next;
        mult_reg       <= mult_next;
        o_reg          <= o_next;
        rem_reg        <= rem_next;
        cnt_reg        <= cnt_next;
        sh_reg         <= sh_next;
        fw_reg         <= fw_next;
        res_prime_reg  <= res_prime_next;
        res_status_reg <= res_status_next;
        m_prime_reg    <= m_prime_next;
        m_status_reg   <= m_status_next;
        for (int k = 0; k < NS; k++) begin
            lane_reg[k] <= lane_next[k];
        end
    end

    always_comb begin
        state_next      = state_reg;
        limit_next      = limit_reg;
        base_next       = base_reg;
        wp_next         = wp_reg;
        bp_next         = bp_reg;
        done_next       = done_reg;
        resume_next     = resume_reg;
        i_next          = i_reg;
        sq_next         = sq_reg;
        mult_next       = mult_reg;
        o_next          = o_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        sh_next         = sh_reg;
        fw_next         = fw_reg;
        res_prime_next  = res_prime_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_prime_next    = m_prime_reg;
        m_status_next   = m_status_reg;
        for (int k = 0; k < NS; k++) begin
            lane_next[k] = lane_reg[k];
        end
        seg_we     = 1'b0;
        seg_re     = 1'b0;
        seg_waddr  = o_reg[SEGB+4:5];
        seg_raddr  = o_reg[SEGB+4:5];
        seg_wdata  = seg_rdata_reg & ~(spsg_pkg::TOP_BIT >> o_reg[4:0]);
        base_we    = 1'b0;
        base_waddr = i_reg[BSB-1:0];
        base_wbit  = 1'b0;
        off_we     = 1'b0;
        off_wdata  = o_reg - OW'(SPAN);
        s_ready    = 1'b0;

        if (psel && penable && pwrite && paddr == spsg_pkg::ADDR_LIMIT) begin
            limit_next = pwdata[LIMIT_BITS-1:0];
        end

        case (state_reg)
            spsg_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_command == spsg_pkg::CMD_NEXT) begin
                        state_next = spsg_pkg::ST_SC_WORD;
                    end else if (s_start_value > limit_reg) begin
                        res_prime_next  = '0;
                        res_status_next = spsg_pkg::STAT_REJECT;
                        state_next      = spsg_pkg::ST_RESP;
                    end else begin
                        base_next   = WBW'(s_start_value[LIMIT_BITS-1:6]);
                        wp_next     = '0;
                        bp_next     = s_start_value[5:1];
                        done_next   = 1'b0;
                        resume_next = 1'b0;
                        i_next      = '0;
                        state_next  = spsg_pkg::ST_BB_FILL;
                    end
                end
            end
            spsg_pkg::ST_BB_FILL: begin
                base_we   = 1'b1;
                base_wbit = (i_reg != '0);
                if (i_reg == IW'(BASE_SLOTS - 1)) begin
                    i_next     = IW'(1);
                    state_next = spsg_pkg::ST_BB_RD;
                end else begin
                    i_next = i_reg + 1'b1;
                end
            end
            spsg_pkg::ST_BB_RD: begin
                sq_next    = SQW'(p_w) * SQW'(p_w);
                state_next = spsg_pkg::ST_BB_CHK;
            end
            spsg_pkg::ST_BB_CHK: begin
                if (sq_reg >= SQW'(2 * BASE_SLOTS)) begin
                    i_next     = IW'(spsg_pkg::FIRST_SIEVE_SLOT);
                    state_next = spsg_pkg::ST_IO_RD;
                end else if (!base_rbit_reg) begin
                    i_next     = i_reg + 1'b1;
                    state_next = spsg_pkg::ST_BB_RD;
                end else begin
                    mult_next  = sq_reg >> 1;
                    state_next = spsg_pkg::ST_BB_CLR;
                end
            end
            spsg_pkg::ST_BB_CLR: begin
                if (mult_reg < SQW'(BASE_SLOTS)) begin
                    base_we    = 1'b1;
                    base_waddr = mult_reg[BSB-1:0];
                    base_wbit  = 1'b0;
                    mult_next  = mult_reg + SQW'(p_w);
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = spsg_pkg::ST_BB_RD;
                end
            end
            spsg_pkg::ST_IO_RD: begin
                sq_next    = SQW'(p_w) * SQW'(p_w);
                state_next = spsg_pkg::ST_IO_CHK;
            end
            spsg_pkg::ST_IO_CHK: begin
                if (base_rbit_reg && sq_ext < seg_ext) begin
                    rem_next   = '0;
                    cnt_next   = '0;
                    sh_next    = seg_start_w;
                    state_next = spsg_pkg::ST_IO_DIV;
                end else begin
                    if (base_rbit_reg) begin
                        off_we    = 1'b1;
                        off_wdata = OW'((sq_ext - seg_ext) >> 1);
                    end
                    if (i_reg == IW'(BASE_SLOTS - 1)) begin
                        state_next = spsg_pkg::ST_WH_SETUP;
                    end else begin
                        i_next     = i_reg + 1'b1;
                        state_next = spsg_pkg::ST_IO_RD;
                    end
                end
            end
            spsg_pkg::ST_IO_DIV: begin
                rem_next = (rem_trial >= {1'b0, p_w}) ? PW'(rem_trial - {1'b0, p_w})
                                                      : PW'(rem_trial);
                sh_next  = sh_reg << 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(NW - 1)) begin
                    state_next = spsg_pkg::ST_IO_FIN;
                end
            end
            spsg_pkg::ST_IO_FIN: begin
                off_we    = 1'b1;
                off_wdata = OW'(d_odd >> 1);
                if (i_reg == IW'(BASE_SLOTS - 1)) begin
                    state_next = spsg_pkg::ST_WH_SETUP;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = spsg_pkg::ST_IO_RD;
                end
            end
            spsg_pkg::ST_WH_SETUP: begin
                sh_next  = seg_start_w + NW'(1);
                cnt_next = '0;
                for (int k = 0; k < NS; k++) begin
                    lane_next[k] = '0;
                end
                state_next = spsg_pkg::ST_WH_INIT;
            end
            spsg_pkg::ST_WH_INIT: begin
                for (int k = 0; k < NS; k++) begin
                    lane_next[k] = init_val[k];
                end
                sh_next  = sh_reg << 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(NW - 1)) begin
                    state_next = spsg_pkg::ST_WH_CONV;
                end
            end
            spsg_pkg::ST_WH_CONV: begin
                for (int k = 0; k < NS; k++) begin
                    lane_next[k] = conv_val[k];
                end
                fw_next    = '0;
                state_next = spsg_pkg::ST_WH_FILL;
            end
            spsg_pkg::ST_WH_FILL: begin
                seg_we    = 1'b1;
                seg_waddr = fw_reg[SEGB-1:0];
                seg_wdata = (base_reg == '0 && fw_reg == '0) ? spsg_pkg::WORD0_MASK : wheel_and;
                for (int k = 0; k < NS; k++) begin
                    lane_next[k] = step_val[k];
                end
                fw_next = fw_reg + 1'b1;
                if (fw_reg == WPW'(SEG_WORDS - 1)) begin
                    i_next     = IW'(spsg_pkg::FIRST_SIEVE_SLOT);
                    state_next = spsg_pkg::ST_CX_RD;
                end
            end
            spsg_pkg::ST_CX_RD: begin
                state_next = spsg_pkg::ST_CX_CHK;
            end
            spsg_pkg::ST_CX_CHK: begin
                if (base_rbit_reg) begin
                    o_next     = off_rdata_reg;
                    state_next = spsg_pkg::ST_CX_TEST;
                end else if (i_reg == IW'(BASE_SLOTS - 1)) begin
                    if (resume_reg) begin
                        state_next = spsg_pkg::ST_SC_WORD;
                    end else begin
                        res_prime_next  = '0;
                        res_status_next = spsg_pkg::STAT_STARTED;
                        state_next      = spsg_pkg::ST_RESP;
                    end
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = spsg_pkg::ST_CX_RD;
                end
            end
            spsg_pkg::ST_CX_TEST: begin
                if (o_reg < OW'(SPAN)) begin
                    seg_re     = 1'b1;
                    state_next = spsg_pkg::ST_CX_WR;
                end else begin
                    off_we = 1'b1;
                    if (i_reg == IW'(BASE_SLOTS - 1)) begin
                        if (resume_reg) begin
                            state_next = spsg_pkg::ST_SC_WORD;
                        end else begin
                            res_prime_next  = '0;
                            res_status_next = spsg_pkg::STAT_STARTED;
                            state_next      = spsg_pkg::ST_RESP;
                        end
                    end else begin
                        i_next     = i_reg + 1'b1;
                        state_next = spsg_pkg::ST_CX_RD;
                    end
                end
            end
            spsg_pkg::ST_CX_WR: begin
                seg_we     = 1'b1;
                o_next     = o_reg + OW'(p_w);
                state_next = spsg_pkg::ST_CX_TEST;
            end
            spsg_pkg::ST_SC_WORD: begin
                if (done_reg) begin
                    res_prime_next  = '0;
                    res_status_next = spsg_pkg::STAT_DONE;
                    state_next      = spsg_pkg::ST_RESP;
                end else if (wp_reg == WPW'(SEG_WORDS)) begin
                    base_next   = base_reg + WBW'(SEG_WORDS);
                    wp_next     = '0;
                    resume_next = 1'b1;
                    state_next  = spsg_pkg::ST_WH_SETUP;
                end else begin
                    seg_re     = 1'b1;
                    seg_raddr  = wp_reg[SEGB-1:0];
                    state_next = spsg_pkg::ST_SC_BIT;
                end
            end
            spsg_pkg::ST_SC_BIT: begin
                if (n_w >= NW'(limit_reg)) begin
                    done_next       = 1'b1;
                    res_prime_next  = '0;
                    res_status_next = spsg_pkg::STAT_DONE;
                    state_next      = spsg_pkg::ST_RESP;
                end else begin
                    bp_next = bp_reg + 1'b1;
                    if (bp_reg == 5'd31) begin
                        wp_next    = wp_reg + 1'b1;
                        state_next = spsg_pkg::ST_SC_WORD;
                    end
                    if (shifted_word[31]) begin
                        res_prime_next  = n_w[LIMIT_BITS-1:0];
                        res_status_next = spsg_pkg::STAT_PRIME;
                        state_next      = spsg_pkg::ST_RESP;
                    end
                end
            end
            spsg_pkg::ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_prime_next  = res_prime_reg;
                    m_status_next = res_status_reg;
                    state_next    = spsg_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = spsg_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid  = m_valid_reg;
    assign m_prime  = m_prime_reg;
    assign m_status = m_status_reg;
    assign prdata   = 32'(limit_reg);
    assign pready   = 1'b1;

`ifndef SYNTHESIS
    a_prime_odd: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == spsg_pkg::STAT_PRIME) |-> m_prime_reg[0])
        else $error("prime item is even");
    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg != spsg_pkg::STAT_PRIME) |-> (m_prime_reg == '0))
        else $error("non-prime item carries a value");
    a_wp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wp_reg <= WPW'(SEG_WORDS))
        else $error("word pointer out of range");
    a_done_answer: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == spsg_pkg::ST_SC_WORD && done_reg) |=>
        (state_reg == spsg_pkg::ST_RESP && res_status_reg == spsg_pkg::STAT_DONE))
        else $error("exhausted scan did not answer done");
    a_cross_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == spsg_pkg::ST_CX_WR) |-> (o_reg < OW'(SPAN)))
        else $error("crossing outside segment");
`endif

endmodule
`default_nettype wire
